FILE: rtl/serial_frame_receiver_unit_macros.svh
// Assertion macros shared by the frame receiver modules
`ifndef SERIAL_FRAME_RECEIVER_UNIT_MACROS_SVH
`define SERIAL_FRAME_RECEIVER_UNIT_MACROS_SVH
`ifndef SYNTH
// Check a property on every clock edge outside reset
`define SFR_ASSERT(label, clk, rst_n, prop) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (prop)) \
    else $error("frame receiver check failed");
// Check that a condition implies another in the next cycle
`define SFR_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("frame receiver sequence check failed");
`else
`define SFR_ASSERT(label, clk, rst_n, prop)
`define SFR_ASSERT_NEXT(label, clk, rst_n, ante, cons)
`endif
`endif

FILE: rtl/sfr_pkg.sv
// Shared types and constants of the serial frame receiver
package sfr_pkg;

  localparam logic [7:0] HDR_FIRST  = 8'hAA;
  localparam logic [7:0] HDR_SECOND = 8'h29;
  localparam logic [7:0] ID_BOUND   = 8'hF1;
  localparam int unsigned CAP_DEPTH = 8;
  localparam int unsigned CAP_IDX_W = $clog2(CAP_DEPTH);

  localparam logic [7:0] TARGET_ID_RST    = 8'h42;
  localparam logic [7:0] LENGTH_LIMIT_RST = 8'd50;

  // Register word addresses (byte address bit 2)
  localparam logic REG_TARGET_ID    = 1'b0;
  localparam logic REG_LENGTH_LIMIT = 1'b1;

  typedef enum logic [2:0] {
    ST_IDLE    = 3'd0,
    ST_HDR2    = 3'd1,
    ST_ID      = 3'd2,
    ST_LEN     = 3'd3,
    ST_PAYLOAD = 3'd4,
    ST_CHECK   = 3'd5
  } sfr_state_t;

  typedef struct packed {
    logic [7:0] target_id;
    logic [7:0] length_limit;
  } sfr_cfg_t;

  typedef struct packed {
    logic               checksum_ok;
    logic               record_valid;
    logic [7:0]         frame_id;
    logic [7:0]         payload_length;
    logic [7:0]         status_flag;
    logic signed [15:0] box_width;
    logic signed [15:0] box_x;
    logic signed [15:0] box_y;
    logic [7:0]         frame_rate;
  } sfr_result_t;

endpackage

FILE: rtl/sfr_cfg_regs.sv
// Configuration registers behind the APB-style port
module sfr_cfg_regs (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              psel,
  input  logic              penable,
  input  logic              pwrite,
  input  logic [2:0]        paddr,
  input  logic [31:0]       pwdata,
  output logic [31:0]       prdata,
  output logic              pready,
  output sfr_pkg::sfr_cfg_t cfg
);

  logic [7:0] target_id_r;
  logic [7:0] target_id_nxt;
  logic [7:0] length_limit_r;
  logic [7:0] length_limit_nxt;
  logic       wr_en;

  assign pready = 1'b1;
  assign wr_en  = psel & penable & pwrite;

  // Decode the write by word address
  always_comb begin
    target_id_nxt    = target_id_r;
    length_limit_nxt = length_limit_r;
    if (wr_en) begin
      unique case (paddr[2])
        sfr_pkg::REG_TARGET_ID:    target_id_nxt    = pwdata[7:0];
        sfr_pkg::REG_LENGTH_LIMIT: length_limit_nxt = pwdata[7:0];
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      target_id_r    <= sfr_pkg::TARGET_ID_RST;
      length_limit_r <= sfr_pkg::LENGTH_LIMIT_RST;
    end else begin
      target_id_r    <= target_id_nxt;
      length_limit_r <= length_limit_nxt;
    end
  end

  // Return the addressed register
  always_comb begin
    unique case (paddr[2])
      sfr_pkg::REG_TARGET_ID:    prdata = {24'd0, target_id_r};
      sfr_pkg::REG_LENGTH_LIMIT: prdata = {24'd0, length_limit_r};
      default:                   prdata = 32'd0;
    endcase
  end

  assign cfg.target_id    = target_id_r;
  assign cfg.length_limit = length_limit_r;

endmodule

FILE: rtl/sfr_frame_core.sv
// Frame hunt state machine, checksum and capture registers
`include "serial_frame_receiver_unit_macros.svh"
module sfr_frame_core (
  input  logic                 clk,
  input  logic                 rst_n,
  input  sfr_pkg::sfr_cfg_t    cfg,
  input  logic                 word_valid,
  input  logic                 fire,
  input  logic [7:0]           rx_byte,
  output logic                 emit,
  output sfr_pkg::sfr_result_t result
);

  sfr_pkg::sfr_state_t state_r;
  sfr_pkg::sfr_state_t state_nxt;
  logic [7:0] dl_r;
  logic [7:0] dl_nxt;
  logic [7:0] cnt_r;
  logic [7:0] cnt_nxt;
  logic [7:0] sum_r;
  logic [7:0] sum_nxt;
  logic [7:0] id_r;
  logic [7:0] id_nxt;
  logic [7:0] cap_r   [sfr_pkg::CAP_DEPTH];
  logic [7:0] cap_nxt [sfr_pkg::CAP_DEPTH];
  logic       capture;
  logic       at_payload;
  logic       at_check;
  logic [7:0] cnt_inc;
  logic       ok;
  logic       rec;

  assign cnt_inc    = cnt_r + 8'd1;
  assign at_payload = (state_r == sfr_pkg::ST_PAYLOAD);
  assign at_check   = (state_r == sfr_pkg::ST_CHECK);
  // Payload and checksum words both go through the capture window
  assign capture    = at_payload || at_check;

  // Next state, sum and capture for the word in hand
  always_comb begin
    state_nxt = state_r;
    dl_nxt    = dl_r;
    cnt_nxt   = cnt_r;
    sum_nxt   = sum_r;
    id_nxt    = id_r;
    unique case (state_r)
      sfr_pkg::ST_IDLE: begin
        if (rx_byte == sfr_pkg::HDR_FIRST) begin
          cnt_nxt   = 8'd0;
          dl_nxt    = 8'd0;
          sum_nxt   = rx_byte;
          state_nxt = sfr_pkg::ST_HDR2;
        end
      end
      sfr_pkg::ST_HDR2: begin
        if (rx_byte == sfr_pkg::HDR_SECOND) begin
          sum_nxt   = sum_r + rx_byte;
          state_nxt = sfr_pkg::ST_ID;
        end else begin
          state_nxt = sfr_pkg::ST_IDLE;
        end
      end
      sfr_pkg::ST_ID: begin
        if (rx_byte < sfr_pkg::ID_BOUND) begin
          sum_nxt   = sum_r + rx_byte;
          id_nxt    = rx_byte;
          state_nxt = sfr_pkg::ST_LEN;
        end else begin
          state_nxt = sfr_pkg::ST_IDLE;
        end
      end
      sfr_pkg::ST_LEN: begin
        if (rx_byte < cfg.length_limit) begin
          sum_nxt   = sum_r + rx_byte;
          dl_nxt    = rx_byte;
          state_nxt = sfr_pkg::ST_PAYLOAD;
        end else begin
          state_nxt = sfr_pkg::ST_IDLE;
        end
      end
      sfr_pkg::ST_PAYLOAD: begin
        sum_nxt = sum_r + rx_byte;
        cnt_nxt = cnt_inc;
        if (cnt_inc >= dl_r) begin
          state_nxt = sfr_pkg::ST_CHECK;
        end
      end
      sfr_pkg::ST_CHECK: begin
        cnt_nxt   = cnt_inc;
        state_nxt = sfr_pkg::ST_IDLE;
      end
      default: state_nxt = sfr_pkg::ST_IDLE;
    endcase
  end

  // Drop the word into its capture slot when it falls inside the window
  always_comb begin
    for (int i = 0; i < sfr_pkg::CAP_DEPTH; i++) begin
      cap_nxt[i] = cap_r[i];
    end
    if (capture && (cnt_r < 8'(sfr_pkg::CAP_DEPTH))) begin
      cap_nxt[cnt_r[sfr_pkg::CAP_IDX_W-1:0]] = rx_byte;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= sfr_pkg::ST_IDLE;
      dl_r    <= 8'd0;
      cnt_r   <= 8'd0;
      sum_r   <= 8'd0;
      id_r    <= 8'd0;
      for (int i = 0; i < sfr_pkg::CAP_DEPTH; i++) begin
        cap_r[i] <= 8'd0;
      end
    end else if (fire) begin
      state_r <= state_nxt;
      dl_r    <= dl_nxt;
      cnt_r   <= cnt_nxt;
      sum_r   <= sum_nxt;
      id_r    <= id_nxt;
      for (int i = 0; i < sfr_pkg::CAP_DEPTH; i++) begin
        cap_r[i] <= cap_nxt[i];
      end
    end
  end

  // Build the frame result from the updated capture window
  assign emit = word_valid && at_check;
  assign ok   = (sum_r == rx_byte);
  assign rec  = ok && (id_r == cfg.target_id);

  always_comb begin
    result.checksum_ok    = ok;
    result.record_valid   = rec;
    result.frame_id       = id_r;
    result.payload_length = dl_r;
    result.status_flag    = 8'd0;
    result.box_width      = 16'sd0;
    result.box_x          = 16'sd0;
    result.box_y          = 16'sd0;
    result.frame_rate     = 8'd0;
    if (rec) begin
      result.status_flag = cap_nxt[0];
      result.box_width   = {cap_nxt[1], cap_nxt[2]};
      result.box_x       = {cap_nxt[3], cap_nxt[4]};
      result.box_y       = {cap_nxt[5], cap_nxt[6]};
      result.frame_rate  = cap_nxt[7];
    end
  end

  // A completed frame always returns the hunt to idle
  `SFR_ASSERT_NEXT(a_check_to_idle, clk, rst_n, fire && at_check, state_r == sfr_pkg::ST_IDLE)
  // Payload count never runs past the declared length
  `SFR_ASSERT(a_payload_count, clk, rst_n, !at_payload || (cnt_r < dl_r) || (cnt_r == 8'd0))

endmodule

FILE: rtl/sfr_out_stage.sv
// Result register towards the output channel
`include "serial_frame_receiver_unit_macros.svh"
module sfr_out_stage (
  input  logic                 clk,
  input  logic                 rst_n,
  input  logic                 load,
  input  sfr_pkg::sfr_result_t result,
  input  logic                 out_stall,
  output logic                 out_valid,
  output logic                 free,
  output sfr_pkg::sfr_result_t out_data
);

  logic                 valid_r;
  logic                 valid_nxt;
  sfr_pkg::sfr_result_t data_r;

  // Free when empty or the held word leaves this cycle
  assign free      = !valid_r || !out_stall;
  assign valid_nxt = load || (valid_r && out_stall);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
    end else begin
      valid_r <= valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (load) begin
      data_r <= result;
    end
  end

  assign out_valid = valid_r;
  assign out_data  = data_r;

  // Never overwrite a word that is still waiting
  `SFR_ASSERT(a_no_overwrite, clk, rst_n, !(load && valid_r && out_stall))
  // A delivered word with nothing behind it empties the stage
  `SFR_ASSERT_NEXT(a_drain, clk, rst_n, valid_r && !out_stall && !load, !valid_r)

endmodule

FILE: rtl/serial_frame_receiver_unit.sv
// Serial frame receiver: byte hunt for checksummed frames and object record decode
//
// Feed received bytes on in_rx_byte with in_valid; a byte is taken at a clock edge
// where in_valid is high and in_stall low. Each completed frame yields one word on
// the out_ channel (checksum status, id, length and the decoded object record);
// other bytes yield nothing. Registers target_id and length_limit sit at byte
// addresses 0 and 4 of the APB-style port; the user must see that they are written
// only while the block is idle, as the block itself does not enforce this. A byte
// taken sits in the input register and is worked on in the following cycle; when
// the last byte of a frame advances, its result is loaded into the result register
// and out_valid rises after that. Throughput: one byte per cycle while in_stall
// is low, set by the single input register feeding hunt FSM and result register.
// The input register keeps taking bytes while a result waits; only a byte that
// would end a frame holds, via in_stall, when the result register is still full
// and out_stall is high.
// Reset (rst_n low, synchronous) returns the hunt to idle, clears sum, count, id and
// the capture window, empties both registers and restores the register defaults.
module serial_frame_receiver_unit (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               in_valid,
  output logic               in_stall,
  input  logic [7:0]         in_rx_byte,
  output logic               out_valid,
  input  logic               out_stall,
  output logic               out_checksum_ok,
  output logic               out_record_valid,
  output logic [7:0]         out_frame_id,
  output logic [7:0]         out_payload_length,
  output logic [7:0]         out_status_flag,
  output logic signed [15:0] out_box_width,
  output logic signed [15:0] out_box_x,
  output logic signed [15:0] out_box_y,
  output logic [7:0]         out_frame_rate,
  input  logic               psel,
  input  logic               penable,
  input  logic               pwrite,
  input  logic [2:0]         paddr,
  input  logic [31:0]        pwdata,
  output logic [31:0]        prdata,
  output logic               pready
);

  sfr_pkg::sfr_cfg_t    cfg;
  sfr_pkg::sfr_result_t result;
  sfr_pkg::sfr_result_t out_data;
  logic                 s1_valid_r;
  logic                 s1_valid_nxt;
  logic [7:0]           s1_byte_r;
  logic                 accept;
  logic                 emit;
  logic                 adv;
  logic                 out_free;

  sfr_cfg_regs u_cfg (
    .clk     (clk),
    .rst_n   (rst_n),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .pready  (pready),
    .cfg     (cfg)
  );

  // Advance the held word unless it ends a frame and the result stage is full and stalled
  assign adv      = s1_valid_r && (!emit || out_free);
  assign in_stall = s1_valid_r && !adv;
  assign accept   = in_valid && !in_stall;

  assign s1_valid_nxt = accept || (s1_valid_r && !adv);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_valid_r <= 1'b0;
    end else begin
      s1_valid_r <= s1_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      s1_byte_r <= in_rx_byte;
    end
  end

  sfr_frame_core u_core (
    .clk        (clk),
    .rst_n      (rst_n),
    .cfg        (cfg),
    .word_valid (s1_valid_r),
    .fire       (adv),
    .rx_byte    (s1_byte_r),
    .emit       (emit),
    .result     (result)
  );

  sfr_out_stage u_out (
    .clk       (clk),
    .rst_n     (rst_n),
    .load      (emit && adv),
    .result    (result),
    .out_stall (out_stall),
    .out_valid (out_valid),
    .free      (out_free),
    .out_data  (out_data)
  );

  assign out_checksum_ok    = out_data.checksum_ok;
  assign out_record_valid   = out_data.record_valid;
  assign out_frame_id       = out_data.frame_id;
  assign out_payload_length = out_data.payload_length;
  assign out_status_flag    = out_data.status_flag;
  assign out_box_width      = out_data.box_width;
  assign out_box_x          = out_data.box_x;
  assign out_box_y          = out_data.box_y;
  assign out_frame_rate     = out_data.frame_rate;

endmodule
